/* rtl/core/pbpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_pkg
// Shared sizes, codes and types for the pinned buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

   localparam int SLOTS      = 64;
   localparam int BLOCKS     = 1024;
   localparam int COUNT_BITS = 16;

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int FILL_BITS  = $clog2(SLOTS + 1);
   localparam int BLK_IDX    = $clog2(BLOCKS);
   localparam int BLOCK_BITS = 10;
   localparam int CFG_BITS   = 7;
   localparam int MAP_BITS   = SLOT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Request modes.
   localparam logic [1:0] MODE_PIN     = 2'd0;
   localparam logic [1:0] MODE_UNPIN   = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   // Region open results.
   localparam logic [1:0] REGION_READY   = 2'd0;
   localparam logic [1:0] REGION_RETRY   = 2'd1;
   localparam logic [1:0] REGION_ERROR   = 2'd2;
   localparam logic [1:0] REGION_UNKNOWN = 2'd3;

   // Response status codes.
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_RETRY      = 3'd1;
   localparam logic [2:0] STAT_DEEP_RETRY = 3'd2;
   localparam logic [2:0] STAT_OPEN_ERR   = 3'd3;
   localparam logic [2:0] STAT_MISUSE     = 3'd4;
   localparam logic [2:0] STAT_IDLE       = 3'd5;

   // Tick actions.
   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_COOLED   = 2'd1;
   localparam logic [1:0] ACT_UNLOADED = 2'd2;
   localparam logic [1:0] ACT_EXAMINED = 2'd3;

   // Slot modes.
   localparam logic [1:0] SM_COLD    = 2'd0;
   localparam logic [1:0] SM_HOT     = 2'd1;
   localparam logic [1:0] SM_COOLING = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_COOLING_TARGET = 1'b0;
   localparam logic CSR_FREE_TARGET    = 1'b1;

   typedef struct packed {
      logic [1:0]            mode;
      logic [COUNT_BITS-1:0] count;
      logic [BLOCK_BITS-1:0] owner;
   } slot_entry_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic rd1;
      logic rd2;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_ready;
   } dp_status_type;

endpackage

/* rtl/core/pinned_buffer_pool_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_buffer_pool_manager
// Buffer slot pool with reader counts, free queue and clock-style cooling.
// ----------------------------------------------------------------------------
// A transfer on req_ is latched; the block map read, slot table read and
// execute step follow, and the result is registered on rsp_. The execute step
// waits while rsp_stall holds the response register; no new request is taken
// before it is done. Reset: synchronous; after reset the block map is swept
// clear while req_stall stays high. Configuration writes are taken throughout.
module pinned_buffer_pool_manager import pbpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [BLOCK_BITS-1:0] req_block_id,
   input  logic                  req_address_valid,
   input  logic [1:0]            req_region_status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_hit,
   output logic [1:0]            rsp_tick_action,
   output logic [FILL_BITS-1:0]  rsp_free_count
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   pbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   pbpm_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_block_id      (req_block_id),
      .req_address_valid (req_address_valid),
      .req_region_status (req_region_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_hit           (rsp_hit),
      .rsp_tick_action   (rsp_tick_action),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

/* rtl/core/pbpm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/pbpm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_ctrl
// Sequencer: map clearing pass, then accept, two read steps and execute.
// ----------------------------------------------------------------------------
module pbpm_ctrl import pbpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD1   = 3'd2;
   localparam logic [2:0] ST_RD2   = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // Hold until the response register can take the result.
            if (dp_status.out_ready) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/pbpm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_datapath
// Slot table, block map, free and cooling queues, and the response register.
// ----------------------------------------------------------------------------
module pbpm_datapath import pbpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         dp_status,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata,
   input  logic [1:0]            req_mode,
   input  logic [BLOCK_BITS-1:0] req_block_id,
   input  logic                  req_address_valid,
   input  logic [1:0]            req_region_status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_hit,
   output logic [1:0]            rsp_tick_action,
   output logic [FILL_BITS-1:0]  rsp_free_count
);

   localparam int ENTRY_BITS = $bits(slot_entry_type);

   // Configuration.
   logic [CFG_BITS-1:0] cool_target_ff, free_target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cool_target_ff <= CFG_BITS'(16);
         free_target_ff <= CFG_BITS'(8);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COOLING_TARGET: cool_target_ff <= csr_wdata;
            CSR_FREE_TARGET:    free_target_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latched request.
   logic [1:0]            mode_ff;
   logic [BLOCK_BITS-1:0] blk_ff;
   logic                  addr_ok_ff;
   logic [1:0]            region_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         blk_ff     <= req_block_id;
         addr_ok_ff <= req_address_valid;
         region_ff  <= req_region_status;
      end
   end

   // Control state of the queues and sweep.
   logic [SLOT_BITS-1:0] free_head_ff, free_head_in;
   logic [FILL_BITS-1:0] free_fill_ff, free_fill_in;
   logic [SLOT_BITS-1:0] cool_head_ff, cool_head_in;
   logic [FILL_BITS-1:0] cool_fill_ff, cool_fill_in;
   logic [SLOT_BITS-1:0] sweep_ff, sweep_in;
   logic [SLOTS-1:0]     slot_vld_ff, slot_vld_in;
   logic [SLOTS-1:0]     free_vld_ff, free_vld_in;
   logic [BLK_IDX-1:0]   clr_ff;
   logic [SLOT_BITS-1:0] sel_ff;

   // Memories.
   logic                  map_we;
   logic [BLK_IDX-1:0]    map_waddr;
   logic [MAP_BITS-1:0]   map_wdata, map_rd;
   logic                  slot_we;
   logic [SLOT_BITS-1:0]  slot_waddr, slot_raddr;
   slot_entry_type        slot_wdata, slot_rd_raw, slot_cur;
   logic                  free_we;
   logic [SLOT_BITS-1:0]  free_waddr, free_rd, free_val;
   logic                  cool_we;
   logic [SLOT_BITS-1:0]  cool_waddr, cool_wdata, cool_rd;

   // Pushed slot value: failed open pushes the popped slot, unload pushes sel.
   logic [SLOT_BITS-1:0] free_wdata;
   assign free_wdata = (mode_ff == MODE_PIN) ? free_val : sel_ff;

   pbpm_ram #(.WIDTH(MAP_BITS), .DEPTH(BLOCKS)) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .re    (cmd.rd1),
      .raddr (blk_ff[BLK_IDX-1:0]),
      .rdata (map_rd)
   );

   pbpm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_slots (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (cmd.rd2),
      .raddr (slot_raddr),
      .rdata (slot_rd_raw)
   );

   pbpm_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_free (
      .clock (clock),
      .we    (free_we),
      .waddr (free_waddr),
      .wdata (free_wdata),
      .re    (cmd.rd1),
      .raddr (free_head_ff),
      .rdata (free_rd)
   );

   pbpm_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_cool (
      .clock (clock),
      .we    (cool_we),
      .waddr (cool_waddr),
      .wdata (cool_wdata),
      .re    (cmd.rd1),
      .raddr (cool_head_ff),
      .rdata (cool_rd)
   );

   // Second read step picks the slot whose table entry the item needs.
   logic sweep_branch;
   assign sweep_branch = (cool_fill_ff < cool_target_ff);

   always_comb begin
      if (mode_ff == MODE_TICK) begin
         slot_raddr = sweep_branch ? sweep_ff : cool_rd;
      end else begin
         slot_raddr = map_rd[SLOT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd2) begin
         sel_ff <= slot_raddr;
      end
   end

   // Entries never written read as cold with no readers.
   always_comb begin
      slot_cur = slot_rd_raw;
      if (!slot_vld_ff[sel_ff]) begin
         slot_cur.mode  = SM_COLD;
         slot_cur.count = '0;
      end
   end

   // An unwritten free queue entry holds its own position.
   assign free_val = free_vld_ff[free_head_ff] ? free_rd : free_head_ff;

   logic                 map_hit;
   logic [2:0]           o_status;
   logic [SLOT_BITS-1:0] o_slot;
   logic                 o_hit;
   logic [1:0]           o_act;
   logic                 free_push;

   always_comb begin
      o_status     = STAT_IDLE;
      o_slot       = '0;
      o_hit        = 1'b0;
      o_act        = ACT_NONE;
      free_head_in = free_head_ff;
      free_fill_in = free_fill_ff;
      cool_head_in = cool_head_ff;
      cool_fill_in = cool_fill_ff;
      sweep_in     = sweep_ff;
      slot_vld_in  = slot_vld_ff;
      free_vld_in  = free_vld_ff;
      map_we       = 1'b0;
      map_waddr    = blk_ff[BLK_IDX-1:0];
      map_wdata    = '0;
      slot_we      = 1'b0;
      slot_waddr   = sel_ff;
      slot_wdata   = slot_cur;
      free_push    = 1'b0;
      free_waddr   = SLOT_BITS'(free_head_ff + free_fill_ff[SLOT_BITS-1:0]);
      cool_we      = 1'b0;
      cool_waddr   = SLOT_BITS'(cool_head_ff + cool_fill_ff[SLOT_BITS-1:0]);
      cool_wdata   = sweep_ff;
      map_hit      = map_rd[SLOT_BITS];

      if (cmd.clear) begin
         map_we    = 1'b1;
         map_waddr = clr_ff;
      end else if (cmd.exec) begin
         unique case (mode_ff)
            MODE_PIN: begin
               if ({1'b0, blk_ff} >= (BLOCK_BITS+1)'(BLOCKS)) begin
                  o_status = STAT_MISUSE;
               end else if (map_hit) begin
                  o_slot = sel_ff;
                  o_hit  = 1'b1;
                  if (slot_cur.count == COUNT_MAX) begin
                     o_status = STAT_MISUSE;
                  end else begin
                     slot_we          = 1'b1;
                     slot_wdata.mode  = SM_HOT;
                     slot_wdata.count = slot_cur.count + 1'b1;
                     slot_vld_in[sel_ff] = 1'b1;
                     o_status = STAT_OK;
                  end
               end else if (!addr_ok_ff) begin
                  o_status = STAT_DEEP_RETRY;
               end else if (free_fill_ff == '0) begin
                  o_status = STAT_RETRY;
               end else if (region_ff != REGION_READY) begin
                  // Failed open: the popped slot goes straight back to the tail.
                  free_push    = 1'b1;
                  free_head_in = free_head_ff + 1'b1;
                  o_status = (region_ff == REGION_RETRY) ? STAT_DEEP_RETRY : STAT_OPEN_ERR;
               end else begin
                  free_head_in = free_head_ff + 1'b1;
                  free_fill_in = free_fill_ff - 1'b1;
                  slot_we      = 1'b1;
                  slot_waddr   = free_val;
                  slot_wdata.mode  = SM_HOT;
                  slot_wdata.count = COUNT_BITS'(1);
                  slot_wdata.owner = blk_ff;
                  slot_vld_in[free_val] = 1'b1;
                  map_we    = 1'b1;
                  map_wdata = {1'b1, free_val};
                  o_slot    = free_val;
                  o_status  = STAT_OK;
               end
            end
            MODE_UNPIN: begin
               if ({1'b0, blk_ff} >= (BLOCK_BITS+1)'(BLOCKS)) begin
                  o_status = STAT_MISUSE;
               end else if (!map_hit) begin
                  o_status = STAT_MISUSE;
               end else begin
                  o_slot = sel_ff;
                  if (slot_cur.mode != SM_HOT || slot_cur.count == '0) begin
                     o_status = STAT_MISUSE;
                  end else begin
                     slot_we          = 1'b1;
                     slot_wdata.count = slot_cur.count - 1'b1;
                     slot_vld_in[sel_ff] = 1'b1;
                     o_status = STAT_OK;
                  end
               end
            end
            MODE_TICK: begin
               if (free_fill_ff >= free_target_ff) begin
                  o_status = STAT_IDLE;
               end else if (sweep_branch) begin
                  o_slot   = sel_ff;
                  o_status = STAT_OK;
                  if (slot_cur.mode == SM_HOT && slot_cur.count == '0
                      && cool_fill_ff < FILL_BITS'(SLOTS)) begin
                     slot_we         = 1'b1;
                     slot_wdata.mode = SM_COOLING;
                     slot_vld_in[sel_ff] = 1'b1;
                     cool_we      = 1'b1;
                     cool_fill_in = cool_fill_ff + 1'b1;
                     o_act = ACT_COOLED;
                  end else begin
                     o_act = ACT_EXAMINED;
                  end
                  sweep_in = sweep_ff + 1'b1;
               end else if (cool_fill_ff == '0) begin
                  o_status = STAT_IDLE;
               end else begin
                  cool_head_in = cool_head_ff + 1'b1;
                  cool_fill_in = cool_fill_ff - 1'b1;
                  o_slot   = sel_ff;
                  o_status = STAT_OK;
                  if (slot_cur.mode == SM_COOLING) begin
                     map_we    = 1'b1;
                     map_waddr = slot_cur.owner[BLK_IDX-1:0];
                     map_wdata = '0;
                     slot_we          = 1'b1;
                     slot_wdata.mode  = SM_COLD;
                     slot_wdata.count = '0;
                     slot_vld_in[sel_ff] = 1'b1;
                     if (free_fill_ff < FILL_BITS'(SLOTS)) begin
                        free_push    = 1'b1;
                        free_fill_in = free_fill_ff + 1'b1;
                     end
                     o_act = ACT_UNLOADED;
                  end else begin
                     // Stale entry: the slot was rescued, just drop it.
                     o_act = ACT_EXAMINED;
                  end
               end
            end
            default: o_status = STAT_IDLE;
         endcase
      end

      free_we = free_push;
      if (free_push) begin
         free_vld_in[free_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         free_fill_ff <= FILL_BITS'(SLOTS);
         cool_head_ff <= '0;
         cool_fill_ff <= '0;
         sweep_ff     <= '0;
         slot_vld_ff  <= '0;
         free_vld_ff  <= '0;
         clr_ff       <= '0;
      end else begin
         free_head_ff <= free_head_in;
         free_fill_ff <= free_fill_in;
         cool_head_ff <= cool_head_in;
         cool_fill_ff <= cool_fill_in;
         sweep_ff     <= sweep_in;
         slot_vld_ff  <= slot_vld_in;
         free_vld_ff  <= free_vld_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   assign dp_status.clear_last = (clr_ff == BLK_IDX'(BLOCKS - 1));

   // Response register.
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;
   logic                 rsp_hit_ff;
   logic [1:0]           rsp_act_ff;
   logic [FILL_BITS-1:0] rsp_free_ff;

   assign dp_status.out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= o_status;
         rsp_slot_ff   <= o_slot;
         rsp_hit_ff    <= o_hit;
         rsp_act_ff    <= o_act;
         rsp_free_ff   <= free_fill_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_tick_action = rsp_act_ff;
   assign rsp_free_count  = rsp_free_ff;

endmodule

/* verif/pbpm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_checker
// Watches the request, response and register ports of the buffer pool
// manager, predicts each response from a private copy of the pool state and
// compares every response field with the oldest prediction.
// ----------------------------------------------------------------------------
module pbpm_checker import pbpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [BLOCK_BITS-1:0] req_block_id,
   input  logic                  req_address_valid,
   input  logic [1:0]            req_region_status,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [2:0]            rsp_status,
   input  logic [SLOT_BITS-1:0]  rsp_slot,
   input  logic                  rsp_hit,
   input  logic [1:0]            rsp_tick_action,
   input  logic [FILL_BITS-1:0]  rsp_free_count,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct {
      logic [2:0]           status;
      logic [SLOT_BITS-1:0] slot;
      logic                 hit;
      logic [1:0]           action;
      logic [FILL_BITS-1:0] free_count;
   } pool_answer_type;

   logic [1:0]            slot_state [SLOTS];
   logic [COUNT_BITS-1:0] readers    [SLOTS];
   logic [BLOCK_BITS-1:0] owner_of   [SLOTS];
   bit                    resident   [BLOCKS];
   logic [SLOT_BITS-1:0]  home_of    [BLOCKS];
   logic [SLOT_BITS-1:0]  free_slots [$];
   logic [SLOT_BITS-1:0]  cooling_slots [$];
   logic [SLOT_BITS-1:0]  sweep_at;
   int unsigned           cool_goal;
   int unsigned           free_goal;
   pool_answer_type       answers [$];

   task automatic clear_pool();
      foreach (slot_state[i]) begin
         slot_state[i] = SM_COLD;
         readers[i]    = '0;
      end
      foreach (resident[i]) resident[i] = 1'b0;
      free_slots.delete();
      cooling_slots.delete();
      for (int i = 0; i < SLOTS; i++) free_slots.push_back(i[SLOT_BITS-1:0]);
      sweep_at  = '0;
      cool_goal = 16;
      free_goal = 8;
      answers.delete();
   endtask

   task automatic apply_request(input logic [1:0] mode, input logic [BLOCK_BITS-1:0] blk,
                                input logic addr_ok, input logic [1:0] region,
                                output pool_answer_type r);
      logic [SLOT_BITS-1:0] s;
      r = '{STAT_IDLE, '0, 1'b0, ACT_NONE, '0};
      case (mode)
         MODE_PIN: begin
            if (resident[blk]) begin
               s = home_of[blk];
               r.slot = s;
               r.hit = 1'b1;
               if (readers[s] == COUNT_MAX) begin
                  r.status = STAT_MISUSE;
               end else begin
                  slot_state[s] = SM_HOT;
                  readers[s]++;
                  r.status = STAT_OK;
               end
            end else if (!addr_ok) begin
               r.status = STAT_DEEP_RETRY;
            end else if (free_slots.size() == 0) begin
               r.status = STAT_RETRY;
            end else begin
               s = free_slots.pop_front();
               if (region != REGION_READY) begin
                  // A failed open hands the slot back to the tail of the free queue.
                  free_slots.push_back(s);
                  r.status = (region == REGION_RETRY) ? STAT_DEEP_RETRY : STAT_OPEN_ERR;
               end else begin
                  owner_of[s]   = blk;
                  resident[blk] = 1'b1;
                  home_of[blk]  = s;
                  slot_state[s] = SM_HOT;
                  readers[s]    = COUNT_BITS'(1);
                  r.slot   = s;
                  r.status = STAT_OK;
               end
            end
         end
         MODE_UNPIN: begin
            if (!resident[blk]) begin
               r.status = STAT_MISUSE;
            end else begin
               s = home_of[blk];
               r.slot = s;
               if (slot_state[s] != SM_HOT || readers[s] == 0) begin
                  r.status = STAT_MISUSE;
               end else begin
                  readers[s]--;
                  r.status = STAT_OK;
               end
            end
         end
         MODE_TICK: begin
            if (free_slots.size() >= free_goal) begin
               r.status = STAT_IDLE;
            end else if (cooling_slots.size() < cool_goal) begin
               s = sweep_at;
               r.slot   = s;
               r.status = STAT_OK;
               if (slot_state[s] == SM_HOT && readers[s] == 0 && cooling_slots.size() < SLOTS)
               begin
                  slot_state[s] = SM_COOLING;
                  cooling_slots.push_back(s);
                  r.action = ACT_COOLED;
               end else begin
                  r.action = ACT_EXAMINED;
               end
               sweep_at = s + 1'b1;
            end else if (cooling_slots.size() == 0) begin
               r.status = STAT_IDLE;
            end else begin
               s = cooling_slots.pop_front();
               r.slot   = s;
               r.status = STAT_OK;
               // A slot that was pinned again after queueing is simply dropped.
               if (slot_state[s] == SM_COOLING) begin
                  resident[owner_of[s]] = 1'b0;
                  slot_state[s] = SM_COLD;
                  readers[s]    = '0;
                  if (free_slots.size() < SLOTS) free_slots.push_back(s);
                  r.action = ACT_UNLOADED;
               end else begin
                  r.action = ACT_EXAMINED;
               end
            end
         end
         default: r.status = STAT_IDLE;
      endcase
      r.free_count = FILL_BITS'(free_slots.size());
   endtask

   task automatic compare_response();
      pool_answer_type e;
      if (answers.size() == 0) begin
         $error("response transfer with no request outstanding");
         fail_count++;
         return;
      end
      e = answers.pop_front();
      if (rsp_status !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, rsp_status);
         fail_count++;
      end
      if (rsp_slot !== e.slot) begin
         $error("slot: expected %0d, got %0d", e.slot, rsp_slot);
         fail_count++;
      end
      if (rsp_hit !== e.hit) begin
         $error("hit: expected %0d, got %0d", e.hit, rsp_hit);
         fail_count++;
      end
      if (rsp_tick_action !== e.action) begin
         $error("tick_action: expected %0d, got %0d", e.action, rsp_tick_action);
         fail_count++;
      end
      if (rsp_free_count !== e.free_count) begin
         $error("free_count: expected %0d, got %0d", e.free_count, rsp_free_count);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pool_answer_type r;
      if (reset) begin
         clear_pool();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COOLING_TARGET: cool_goal = csr_wdata;
               CSR_FREE_TARGET:    free_goal = csr_wdata;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_response();
         if (req_valid && !req_stall) begin
            apply_request(req_mode, req_block_id, req_address_valid, req_region_status, r);
            answers.push_back(r);
         end
      end
      pending_count <= answers.size();
   end

endmodule

/* verif/tb_pinned_buffer_pool_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pinned_buffer_pool_manager
// Drives pin, unpin and tick requests into the buffer pool manager under
// random sender gaps and receiver stalls, across several target settings,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_pinned_buffer_pool_manager;
   import pbpm_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_COOLING_TARGET;
   logic [CFG_BITS-1:0]   csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_mode = MODE_PIN;
   logic [BLOCK_BITS-1:0] req_block_id = '0;
   logic                  req_address_valid = 1'b0;
   logic [1:0]            req_region_status = REGION_READY;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_status;
   logic [SLOT_BITS-1:0]  rsp_slot;
   logic                  rsp_hit;
   logic [1:0]            rsp_tick_action;
   logic [FILL_BITS-1:0]  rsp_free_count;
   int                    fail_count;
   int                    pending_count;

   bit calm = 1'b0;
   bit rsp_took = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   pinned_buffer_pool_manager dut (.*);
   pbpm_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Receiver side: after each response transfer, hold off for a drawn number of cycles.
   always @(posedge clock) rsp_took <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_took) stall_left = calm ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL pinned_buffer_pool_manager");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send(input logic [1:0] mode, input logic [BLOCK_BITS-1:0] blk,
                       input logic addr_ok, input logic [1:0] region);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_block_id      <= blk;
      req_address_valid <= addr_ok;
      req_region_status <= region;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [1:0]            mode;
      logic [BLOCK_BITS-1:0] blk;
      logic [1:0]            region;
      int                    pick;
      pick = $urandom_range(0, 99);
      mode = (pick < 40) ? MODE_PIN : (pick < 70) ? MODE_UNPIN :
             (pick < 95) ? MODE_TICK : MODE_UNKNOWN;
      blk  = ($urandom_range(0, 99) < 85) ? BLOCK_BITS'($urandom_range(0, 79))
                                          : BLOCK_BITS'($urandom_range(0, 1023));
      region = ($urandom_range(0, 4) != 0) ? REGION_READY : 2'($urandom_range(1, 3));
      send(mode, blk, $urandom_range(0, 9) != 0, region);
   endtask

   // Lets the block finish all outstanding work before a register write.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_targets(input int cool_goal, input int free_goal);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_COOLING_TARGET;
      csr_wdata <= CFG_BITS'(cool_goal);
      @(negedge clock);
      csr_index <= CSR_FREE_TARGET;
      csr_wdata <= CFG_BITS'(free_goal);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int cool_set [6] = '{16, 0, 64, 1, 64, 0};
      int free_set [6] = '{8, 0, 64, 64, 1, 0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: hits, every miss outcome but an empty free queue, bad unpins, unknown mode, idle tick.
      send(MODE_PIN, 10'd0, 1'b1, REGION_READY);
      send(MODE_PIN, 10'd0, 1'b0, REGION_UNKNOWN);
      send(MODE_PIN, 10'd1023, 1'b1, REGION_RETRY);
      send(MODE_PIN, 10'd5, 1'b1, REGION_ERROR);
      send(MODE_PIN, 10'd5, 1'b1, REGION_UNKNOWN);
      send(MODE_PIN, 10'd6, 1'b0, REGION_READY);
      send(MODE_UNPIN, 10'd0, 1'b1, REGION_READY);
      send(MODE_UNPIN, 10'd0, 1'b0, REGION_READY);
      send(MODE_UNPIN, 10'd0, 1'b0, REGION_READY);
      send(MODE_UNPIN, 10'd700, 1'b0, REGION_READY);
      send(MODE_UNKNOWN, 10'd1023, 1'b1, REGION_UNKNOWN);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);
      set_targets(0, 64);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);
      set_targets(64, 64);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);
      set_targets(0, 64);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);
      send(MODE_TICK, 10'd0, 1'b0, REGION_READY);

      // Structured pass: fill the pool, release it, cool it, rescue some, unload.
      set_targets(64, 64);
      for (int b = 200; b < 265; b++) send(MODE_PIN, BLOCK_BITS'(b), 1'b1, REGION_READY);
      for (int b = 200; b < 264; b++) send(MODE_UNPIN, BLOCK_BITS'(b), 1'b1, REGION_READY);
      for (int i = 0; i < 66; i++) send(MODE_TICK, BLOCK_BITS'($urandom), 1'b0, REGION_READY);
      for (int b = 200; b < 264; b += 3) send(MODE_PIN, BLOCK_BITS'(b), 1'b1, REGION_READY);
      set_targets(0, 64);
      for (int i = 0; i < 70; i++) send(MODE_TICK, BLOCK_BITS'($urandom), 1'b0, REGION_READY);

      // Random phases over several target settings, one of them without idling.
      for (int p = 0; p < 6; p++) begin
         if (p == 5) set_targets($urandom_range(0, 64), $urandom_range(0, 64));
         else set_targets(cool_set[p], free_set[p]);
         calm = (p == 2);
         for (int i = 0; i < 90; i++) send_random();
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS pinned_buffer_pool_manager");
      end else begin
         $display("FAIL pinned_buffer_pool_manager");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/pbpm_pkg.sv
rtl/core/pbpm_ram.sv
rtl/core/pbpm_ctrl.sv
rtl/core/pbpm_datapath.sv
rtl/core/pinned_buffer_pool_manager.sv
verif/pbpm_checker.sv
verif/tb_pinned_buffer_pool_manager.sv
